// ===== hdl/ir_bsm_pkg.sv =====
package ir_bsm_pkg;

  // Sizing of the code matcher
  localparam int NUM_CODES = 4;
  localparam int CODE_BITS = 32;
  // Code words that the configuration port can reach, and that the mask reports
  localparam int CFG_CODES = 4;

  localparam int WORD_W     = 32;
  localparam int DURATION_W = 16;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DURATION_W-1:0] DURATION_RESET = DURATION_W'(400);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DURATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_WORD_BASE = 3'd1;

  typedef struct packed {
    logic [DURATION_W-1:0]             bit_duration_us;
    logic [NUM_CODES-1:0][WORD_W-1:0]  code_word;
  } cfg_t;

  typedef struct packed {
    logic              pin_level;
    logic [WORD_W-1:0] now_us;
    logic [WORD_W-1:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic              bit_taken;
    logic              bit_value;
    logic [WORD_W-1:0] code_shift;
    logic [MASK_W-1:0] match_mask;
    logic [WORD_W-1:0] last_match_ms;
  } result_t;

endpackage

// ===== hdl/ir_bsm_cfg_regs.sv =====
module ir_bsm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ir_bsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output ir_bsm_pkg::cfg_t               cfg
);
  import ir_bsm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode the register index; writes to unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_BIT_DURATION) begin
        cfg_nxt.bit_duration_us = cfg_data[DURATION_W-1:0];
      end
      for (int i = 0; i < NUM_CODES; i++) begin
        if ((i < CFG_CODES) && (cfg_index == (CFG_IDX_W'(i) + CFG_CODE_WORD_BASE))) begin
          cfg_nxt.code_word[i] = cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_duration_us <= DURATION_RESET;
      cfg_r.code_word       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/ir_bsm_core.sv =====
module ir_bsm_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  ir_bsm_pkg::in_beat_t  beat,
  input  ir_bsm_pkg::cfg_t      cfg,
  output ir_bsm_pkg::result_t   result
);
  import ir_bsm_pkg::*;

  logic                 prev_level_r, prev_level_nxt;
  logic [WORD_W-1:0]    last_bit_time_r, last_bit_time_nxt;
  logic [CODE_BITS-1:0] shift_r, shift_nxt;
  logic [WORD_W-1:0]    any_match_r, any_match_nxt;

  logic                 bit_v;
  logic [WORD_W-1:0]    elapsed;
  logic                 taken;
  logic [NUM_CODES-1:0] hit;
  logic [MASK_W-1:0]    mask;
  logic [63:0]          word_ext;
  logic [63:0]          shift_ext;

  // Decide whether this sample is a bit: level change or timeout
  assign bit_v   = ~beat.pin_level;
  assign elapsed = beat.now_us - last_bit_time_r;
  assign taken   = (bit_v != prev_level_r) ||
                   (elapsed > {{(WORD_W-DURATION_W){1'b0}}, cfg.bit_duration_us});

  // Shift the bit in and compare with every code word in parallel
  always_comb begin
    shift_nxt = taken ? {shift_r[CODE_BITS-2:0], bit_v} : shift_r;
    hit       = '0;
    mask      = '0;
    word_ext  = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      word_ext = 64'(cfg.code_word[i]);
      hit[i]   = taken && (word_ext[CODE_BITS-1:0] == shift_nxt);
      if (i < MASK_W) begin
        mask[i] = hit[i];
      end
    end
  end

  assign prev_level_nxt    = bit_v;
  assign last_bit_time_nxt = taken ? beat.now_us : last_bit_time_r;
  assign any_match_nxt     = (|hit) ? beat.now_ms : any_match_r;
  assign shift_ext         = 64'(shift_nxt);

  // Result of the current beat
  always_comb begin
    result.bit_taken     = taken;
    result.bit_value     = bit_v;
    result.code_shift    = shift_ext[WORD_W-1:0];
    result.match_mask    = mask;
    result.last_match_ms = any_match_nxt;
  end

  // Advance the receiver state on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r    <= 1'b0;
      last_bit_time_r <= '0;
      shift_r         <= '0;
      any_match_r     <= '0;
    end else if (fire) begin
      prev_level_r    <= prev_level_nxt;
      last_bit_time_r <= last_bit_time_nxt;
      shift_r         <= shift_nxt;
      any_match_r     <= any_match_nxt;
    end
  end

`ifndef SYNTHESIS
  a_shift_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && taken) |=> $stable(shift_r))
    else $error("shift register changed without a bit");

  a_mask_needs_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (result.match_mask != '0) |-> result.bit_taken)
    else $error("match reported without a bit");

  a_edge_is_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (bit_v != prev_level_r)) |=> (last_bit_time_r == $past(beat.now_us)))
    else $error("level change did not stamp the bit time");

  a_match_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (|hit)) |=> (any_match_r == $past(beat.now_ms)))
    else $error("match did not stamp the match time");
`endif

endmodule

// ===== hdl/ir_bit_sampler_code_matcher.sv =====
// Channel  Direction  Payload (tdata, lowest bit first)
// in_      slave      pin_level[0], now_us[32:1], now_ms[64:33], zero fill
// out_     master     bit_taken[0], bit_value[1], code_shift[33:2],
//                     match_mask[37:34], last_match_ms[69:38], zero fill
// cfg_     write      cfg_index selects the register, cfg_data carries the value
//
// One beat per cycle sustained while out_tready holds; a beat's result is offered once
// it has passed the input register, and it then sits in the result register.
// The bit decision, shift and code compare run combinationally between them.
// rst_n is synchronous: state, valid flags and config reset to defaults, data does not.
// Stalls on out_tready hold the result register; the input register still takes
// a beat while it is empty or draining, so intake stops only once both are full.
module ir_bit_sampler_code_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [71:0]                      in_tdata,   // pin_level, now_us, now_ms
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [71:0]                      out_tdata,  // bit_taken, bit_value,
                                                       // code_shift, match_mask,
                                                       // last_match_ms
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ir_bsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);
  import ir_bsm_pkg::*;

  cfg_t     cfg;
  in_beat_t s1_beat_r;
  logic     s1_valid_r, s1_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  result_t  out_res_r;
  result_t  result;
  logic     s1_fire;
  logic     out_free;

  ir_bsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ir_bsm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .beat   (s1_beat_r),
    .cfg    (cfg),
    .result (result)
  );

  // Pipeline flow control
  assign out_free      = !out_valid_r || out_tready;
  assign s1_fire       = s1_valid_r && out_free;
  assign in_tready     = !s1_valid_r || s1_fire;
  assign s1_valid_nxt  = (in_tvalid && in_tready) || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_beat_r.pin_level <= in_tdata[0];
      s1_beat_r.now_us    <= in_tdata[32:1];
      s1_beat_r.now_ms    <= in_tdata[64:33];
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.last_match_ms, out_res_r.match_mask,
                       out_res_r.code_shift, out_res_r.bit_value, out_res_r.bit_taken};

endmodule
